[src/c2d_pkg.sv]
// c2d_pkg: widths, register indexes and reset values for the valid-window convolution
// no dependencies; used by the interfaces and every module of the block but c2d_ram
package c2d_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 16;
  localparam int PROD_W         = SAMPLE_W + COEF_W;
  localparam int RESULT_W       = 40;
  localparam int XY_W           = 10;
  localparam int CFG_W          = 11;
  localparam int HK_W           = 2;
  localparam int KIDX_W         = 3;
  localparam int PDATA_W        = 32;
  localparam int PADDR_W        = 4;
  localparam int MAX_LINE_DEF   = 1024;
  localparam int MAX_KERNEL_DEF = 5;
  localparam int MAX_ROWS       = 1024;

  localparam logic [1:0] REG_PIX_PER_ROW    = 2'd0;
  localparam logic [1:0] REG_ROWS_PER_FRAME = 2'd1;
  localparam logic [1:0] REG_HALF_KW        = 2'd2;
  localparam logic [1:0] REG_HALF_KH        = 2'd3;

  localparam logic [CFG_W-1:0] RST_PIX_PER_ROW    = 11'd1024;
  localparam logic [CFG_W-1:0] RST_ROWS_PER_FRAME = 11'd1024;
  localparam logic [HK_W-1:0]  RST_HALF_KW        = 2'd1;
  localparam logic [HK_W-1:0]  RST_HALF_KH        = 2'd1;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_COEF   = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

endpackage

[src/c2d_if.sv]
// c2d_in_if and c2d_out_if: valid/ready channels for pixel/coefficient items and results
// depends on c2d_pkg
interface c2d_in_if;
  import c2d_pkg::*;
  logic                valid;
  logic                ready;
  logic                action;
  sample_t             sample;
  logic [KIDX_W-1:0]   coef_col;
  logic [KIDX_W-1:0]   coef_row;
  coef_t               coef_value;
  modport source (output valid, action, sample, coef_col, coef_row, coef_value, input ready);
  modport sink   (input valid, action, sample, coef_col, coef_row, coef_value, output ready);
endinterface

interface c2d_out_if;
  import c2d_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [XY_W-1:0]            out_x;
  logic [XY_W-1:0]            out_y;
  logic signed [RESULT_W-1:0] result;
  logic                       frame_last;
  modport source (output valid, out_x, out_y, result, frame_last, input ready);
  modport sink   (input valid, out_x, out_y, result, frame_last, output ready);
endinterface

[src/c2d_ram.sv]
// c2d_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/c2d_cell.sv]
// c2d_cell: one window column; holds its samples, passes them on, forms a column sum
// depends on c2d_pkg
module c2d_cell #(
  parameter int MAX_KERNEL = c2d_pkg::MAX_KERNEL_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    shift,
  input  c2d_pkg::sample_t        col_in  [MAX_KERNEL],
  input  c2d_pkg::coef_t          coef    [MAX_KERNEL],
  output c2d_pkg::sample_t        col_out [MAX_KERNEL],
  output logic signed [c2d_pkg::PROD_W+$clog2(MAX_KERNEL)-1:0] col_sum
);
  import c2d_pkg::*;

  localparam int CSW = PROD_W + $clog2(MAX_KERNEL);

  sample_t               hold [MAX_KERNEL];
  prod_t                 prod [MAX_KERNEL];
  logic signed [CSW-1:0] sum_next;

  always_ff @(posedge clk) begin
    if (shift) begin
      hold <= col_in;
    end
    if (en) begin
      for (int r = 0; r < MAX_KERNEL; r++) begin
        prod[r] <= hold[r] * coef[r];
      end
      col_sum <= sum_next;
    end
  end

  always_comb begin
    sum_next = '0;
    for (int r = 0; r < MAX_KERNEL; r++) begin
      sum_next = sum_next + CSW'(prod[r]);
    end
  end

  assign col_out = hold;

endmodule

[src/conv2d_valid_window.sv]
// conv2d_valid_window: top level, line store banks, row of window cells and final sum
// depends on c2d_pkg, c2d_if, c2d_ram and c2d_cell
//
//  channel | dir | handshake      | payload
//  pix     | in  | valid/ready    | action, sample, coef_col, coef_row, coef_value
//  res     | out | valid/ready    | out_x, out_y, result, frame_last
//  apb     | in  | psel/penable   | paddr, pwdata, prdata (pready tied high)
//
// one item per cycle unless stalled; results pass stages v1 to v4, then the output
// throughput is set by the single line store access per pixel and the cell row shift
// rst clears counters, stage valids, kernel store and config registers
// a result held at the output stalls the whole pipe, including input acceptance
module conv2d_valid_window #(
  parameter int MAX_LINE   = c2d_pkg::MAX_LINE_DEF,
  parameter int MAX_KERNEL = c2d_pkg::MAX_KERNEL_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  c2d_in_if.sink                       pix,
  c2d_out_if.source                    res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [c2d_pkg::PADDR_W-1:0]  paddr,
  input  logic [c2d_pkg::PDATA_W-1:0]  pwdata,
  output logic [c2d_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import c2d_pkg::*;

  localparam int XW   = $clog2(MAX_LINE);
  localparam int RW   = $clog2(MAX_KERNEL);
  localparam int HKC  = MAX_KERNEL / 2;
  localparam int CSW  = PROD_W + $clog2(MAX_KERNEL);
  localparam int TW   = CSW + $clog2(MAX_KERNEL);

  typedef struct packed {
    logic              pixel;
    logic              prod;
    logic [XY_W-1:0]   ox;
    logic [XY_W-1:0]   oy;
    logic              last;
    logic [KIDX_W-1:0] ccol;
    logic [KIDX_W-1:0] crow;
    coef_t             cval;
  } meta_t;

  // configuration
  logic [CFG_W-1:0] pix_per_row, rows_per_frame;
  logic [HK_W-1:0]  half_kw, half_kh;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_per_row    <= RST_PIX_PER_ROW;
      rows_per_frame <= RST_ROWS_PER_FRAME;
      half_kw        <= RST_HALF_KW;
      half_kh        <= RST_HALF_KH;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_PIX_PER_ROW:    pix_per_row    <= pwdata[CFG_W-1:0];
        REG_ROWS_PER_FRAME: rows_per_frame <= pwdata[CFG_W-1:0];
        REG_HALF_KW:        half_kw        <= pwdata[HK_W-1:0];
        REG_HALF_KH:        half_kh        <= pwdata[HK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PIX_PER_ROW:    prdata = PDATA_W'(pix_per_row);
      REG_ROWS_PER_FRAME: prdata = PDATA_W'(rows_per_frame);
      REG_HALF_KW:        prdata = PDATA_W'(half_kw);
      REG_HALF_KH:        prdata = PDATA_W'(half_kh);
      default:            prdata = '0;
    endcase
  end

  // clamped sizes
  logic [31:0] w_c, h_c, hw_c, hh_c;

  always_comb begin
    w_c  = 32'(pix_per_row);
    h_c  = 32'(rows_per_frame);
    hw_c = 32'(half_kw);
    hh_c = 32'(half_kh);
    if (w_c == 0) w_c = 32'd1;
    if (w_c > 32'(MAX_LINE)) w_c = 32'(MAX_LINE);
    if (h_c == 0) h_c = 32'd1;
    if (h_c > 32'(MAX_ROWS)) h_c = 32'(MAX_ROWS);
    if (hw_c > 32'(HKC)) hw_c = 32'(HKC);
    if (hh_c > 32'(HKC)) hh_c = 32'(HKC);
  end

  // pipeline control
  logic en, accept;
  logic v1, v2, v3, v4;
  meta_t m1, m2, m3, m4;

  assign en        = !res.valid || res.ready;
  assign pix.ready = en;
  assign accept    = pix.valid && en;

  // position counters
  logic [XW-1:0]   x;
  logic [XY_W-1:0] y;
  logic [RW-1:0]   ring;
  logic            is_pix;
  meta_t           m0;

  assign is_pix = (pix.action == ACT_SAMPLE);

  always_comb begin
    m0.pixel = is_pix;
    m0.prod  = is_pix && (32'(x) < w_c) && (32'(y) < h_c)
               && (32'(x) >= (hw_c << 1)) && (32'(y) >= (hh_c << 1));
    m0.ox    = XY_W'(32'(x) - hw_c);
    m0.oy    = XY_W'(32'(y) - hh_c);
    m0.last  = (32'(x) == w_c - 32'd1) && (32'(y) == h_c - 32'd1);
    m0.ccol  = pix.coef_col;
    m0.crow  = pix.coef_row;
    m0.cval  = pix.coef_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x    <= '0;
      y    <= '0;
      ring <= '0;
    end else if (accept && is_pix) begin
      if (32'(x) + 32'd1 >= w_c) begin
        x <= '0;
        if (32'(y) + 32'd1 >= h_c) begin
          y    <= '0;
          ring <= '0;
        end else begin
          y    <= y + XY_W'(1);
          ring <= (32'(ring) == 32'(MAX_KERNEL - 1)) ? '0 : ring + RW'(1);
        end
      end else begin
        x <= x + XW'(1);
      end
    end
  end

  // line store, one bank per row of the ring
  sample_t rdata [MAX_KERNEL];

  for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
    c2d_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LINE)) u_ram (
      .clk   (clk),
      .we    (accept && is_pix && (32'(ring) == b)),
      .waddr (x),
      .wdata (pix.sample),
      .re    (en),
      .raddr (x),
      .rdata (rdata[b])
    );
  end

  // stage registers
  sample_t       smp1;
  logic [RW-1:0] ring1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1    <= m0;
      smp1  <= pix.sample;
      ring1 <= ring;
      m2    <= m1;
      m3    <= m2;
      m4    <= m3;
    end
  end

  // new column, youngest row first
  sample_t col0 [MAX_KERNEL];

  always_comb begin
    for (int r = 0; r < MAX_KERNEL; r++) begin
      if (r == 0) begin
        col0[r] = smp1;
      end else if (32'(ring1) >= 32'(r)) begin
        col0[r] = rdata[RW'(32'(ring1) - 32'(r))];
      end else begin
        col0[r] = rdata[RW'(32'(ring1) + 32'(MAX_KERNEL) - 32'(r))];
      end
    end
  end

  // kernel store, written in order with pixels at the product stage
  coef_t kernel [MAX_KERNEL][MAX_KERNEL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_KERNEL; r++) begin
        for (int c = 0; c < MAX_KERNEL; c++) begin
          kernel[r][c] <= '0;
        end
      end
    end else if (en && v2 && !m2.pixel && (32'(m2.ccol) < 32'(MAX_KERNEL))
                 && (32'(m2.crow) < 32'(MAX_KERNEL))) begin
      kernel[RW'(m2.crow)][RW'(m2.ccol)] <= m2.cval;
    end
  end

  // coefficient for cell j (column age) and row age r
  coef_t coef [MAX_KERNEL][MAX_KERNEL];

  always_comb begin
    for (int j = 0; j < MAX_KERNEL; j++) begin
      for (int r = 0; r < MAX_KERNEL; r++) begin
        coef[j][r] = '0;
        if ((32'(j) <= (hw_c << 1)) && (32'(r) <= (hh_c << 1))) begin
          coef[j][r] = kernel[RW'((hh_c << 1) - 32'(r))][RW'((hw_c << 1) - 32'(j))];
        end
      end
    end
  end

  // row of cells
  sample_t               link [MAX_KERNEL+1][MAX_KERNEL];
  logic signed [CSW-1:0] col_sum [MAX_KERNEL];
  logic                  shift;

  assign shift   = en && v1 && m1.pixel;
  assign link[0] = col0;

  for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_cell
    c2d_cell #(.MAX_KERNEL(MAX_KERNEL)) u_cell (
      .clk     (clk),
      .en      (en),
      .shift   (shift),
      .col_in  (link[j]),
      .coef    (coef[j]),
      .col_out (link[j+1]),
      .col_sum (col_sum[j])
    );
  end

  // final sum and output register
  logic signed [TW-1:0] total;

  always_comb begin
    total = '0;
    for (int j = 0; j < MAX_KERNEL; j++) begin
      total = total + TW'(col_sum[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= v4 && m4.prod;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.out_x      <= m4.ox;
      res.out_y      <= m4.oy;
      res.result     <= RESULT_W'(total);
      res.frame_last <= m4.last;
    end
  end

endmodule

[tb/testbench.sv]
// testbench: self-checking bench for conv2d_valid_window, the valid-window 2d convolution
// depends on c2d_pkg, c2d_in_if, c2d_out_if and the rtl of the block
// an in-bench predictor computes each interior result; both sides idle at random
module testbench;
  import c2d_pkg::*;

  localparam int NUM_LINES   = 5;
  localparam int LINE_LEN    = 1024;
  localparam int CYCLE_CAP   = 1000000;
  localparam int DRAIN_WAIT  = 12;
  localparam int ITEM_TARGET = 1450;
  localparam int IDLE_STOP   = 1350;

  typedef struct packed {
    logic [XY_W-1:0]     x;
    logic [XY_W-1:0]     y;
    logic [RESULT_W-1:0] val;
    logic                last;
  } conv_out_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  c2d_in_if  pix_if ();
  c2d_out_if res_if ();

  conv2d_valid_window u_dut (
    .clk     (clk),
    .rst     (rst),
    .pix     (pix_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  sample_t          line_mem [NUM_LINES][LINE_LEN];
  coef_t            kern [NUM_LINES][NUM_LINES];
  logic [CFG_W-1:0] reg_width;
  logic [CFG_W-1:0] reg_height;
  logic [HK_W-1:0]  reg_hkw;
  logic [HK_W-1:0]  reg_hkh;
  int               col_pos;
  int               row_pos;

  conv_out_t pending_results[$];
  int        errors;
  int        cycles;
  int        sent_items;
  bit        src_idle_on;
  bit        snk_idle_on;
  int        snk_stall;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // result checker
  initial begin
    conv_out_t exp_r;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          report($sformatf("unexpected result x=%0d y=%0d", res_if.out_x, res_if.out_y));
        end else begin
          exp_r = pending_results.pop_front();
          if (res_if.out_x !== exp_r.x)
            report($sformatf("out_x %0d, want %0d", res_if.out_x, exp_r.x));
          if (res_if.out_y !== exp_r.y)
            report($sformatf("out_y %0d, want %0d", res_if.out_y, exp_r.y));
          if (res_if.result !== exp_r.val)
            report($sformatf("result %h, want %h at x=%0d y=%0d",
                             res_if.result, exp_r.val, exp_r.x, exp_r.y));
          if (res_if.frame_last !== exp_r.last)
            report($sformatf("frame_last %b, want %b", res_if.frame_last, exp_r.last));
        end
      end
    end
  end

  // result-side stalls
  initial begin
    snk_stall = 0;
    forever begin
      @(negedge clk);
      if (snk_stall > 0) begin
        res_if.ready = 1'b0;
        snk_stall--;
      end else if (snk_idle_on && $urandom_range(0, 11) == 0) begin
        snk_stall = $urandom_range(0, 17);
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  function automatic int eff_width();
    if (reg_width == 0) return 1;
    if (reg_width > LINE_LEN) return LINE_LEN;
    return int'(reg_width);
  endfunction

  function automatic int eff_height();
    if (reg_height == 0) return 1;
    if (reg_height > MAX_ROWS) return MAX_ROWS;
    return int'(reg_height);
  endfunction

  // window sum for one accepted pixel, kernel update for an accepted coefficient item
  task automatic predict_conv(input logic act, input sample_t smp, input logic [KIDX_W-1:0] kc,
                              input logic [KIDX_W-1:0] kr, input coef_t kv);
    int w, h, hw, hh, x0, y0;
    longint acc;
    conv_out_t r;
    if (act == ACT_COEF) begin
      if (kc < NUM_LINES && kr < NUM_LINES) kern[kr][kc] = kv;
      return;
    end
    w  = eff_width();
    h  = eff_height();
    hw = (reg_hkw > 2) ? 2 : int'(reg_hkw);
    hh = (reg_hkh > 2) ? 2 : int'(reg_hkh);
    if (col_pos < LINE_LEN) line_mem[row_pos % NUM_LINES][col_pos] = smp;
    if (col_pos < w && row_pos < h && col_pos >= 2 * hw && row_pos >= 2 * hh) begin
      acc = 0;
      x0 = col_pos - 2 * hw;
      y0 = row_pos - 2 * hh;
      for (int ky = 0; ky <= 2 * hh; ky++)
        for (int kx = 0; kx <= 2 * hw; kx++)
          acc += longint'(line_mem[(y0 + ky) % NUM_LINES][x0 + kx]) * longint'(kern[ky][kx]);
      r.x    = XY_W'(col_pos - hw);
      r.y    = XY_W'(row_pos - hh);
      r.val  = acc[RESULT_W-1:0];
      r.last = (col_pos == w - 1 && row_pos == h - 1);
      pending_results.push_back(r);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic send_item(input logic act, input sample_t smp, input logic [KIDX_W-1:0] kc,
                           input logic [KIDX_W-1:0] kr, input coef_t kv);
    @(negedge clk);
    if (src_idle_on && $urandom_range(0, 9) == 0) begin
      pix_if.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    pix_if.valid      = 1'b1;
    pix_if.action     = act;
    pix_if.sample     = smp;
    pix_if.coef_col   = kc;
    pix_if.coef_row   = kr;
    pix_if.coef_value = kv;
    do @(posedge clk); while (!pix_if.ready);
    sent_items++;
    predict_conv(act, smp, kc, kr, kv);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input sample_t smp);
    send_item(ACT_SAMPLE, smp, KIDX_W'($urandom), KIDX_W'($urandom), coef_t'($urandom));
  endtask

  task automatic send_coef(input int kc, input int kr, input coef_t kv);
    send_item(ACT_COEF, sample_t'($urandom), KIDX_W'(kc), KIDX_W'(kr), kv);
  endtask

  // wait for every expected result, then for anything still in flight
  task automatic drain();
    @(negedge clk);
    pix_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic finish_frame();
    do send_pixel(rand_sample()); while (col_pos != 0 || row_pos != 0);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = PADDR_W'(idx) << 2; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_PIX_PER_ROW:    reg_width  = val[CFG_W-1:0];
      REG_ROWS_PER_FRAME: reg_height = val[CFG_W-1:0];
      REG_HALF_KW:        reg_hkw    = val[HK_W-1:0];
      default:            reg_hkh    = val[HK_W-1:0];
    endcase
  endtask

  task automatic apb_check(input logic [1:0] idx, input logic [PDATA_W-1:0] want);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b0; penable = 1'b0; paddr = PADDR_W'(idx) << 2;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== want) report($sformatf("register %0d reads %h, want %h", idx, prdata, want));
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  task automatic set_image(input int w, input int h, input int hkw, input int hkh);
    apb_write(REG_PIX_PER_ROW, w);
    apb_write(REG_ROWS_PER_FRAME, h);
    apb_write(REG_HALF_KW, hkw);
    apb_write(REG_HALF_KH, hkh);
    apb_check(REG_PIX_PER_ROW, PDATA_W'(reg_width));
    apb_check(REG_ROWS_PER_FRAME, PDATA_W'(reg_height));
    apb_check(REG_HALF_KW, PDATA_W'(reg_hkw));
    apb_check(REG_HALF_KH, PDATA_W'(reg_hkh));
  endtask

  task automatic test_reset_values();
    apb_check(REG_PIX_PER_ROW, PDATA_W'(RST_PIX_PER_ROW));
    apb_check(REG_ROWS_PER_FRAME, PDATA_W'(RST_ROWS_PER_FRAME));
    apb_check(REG_HALF_KW, PDATA_W'(RST_HALF_KW));
    apb_check(REG_HALF_KH, PDATA_W'(RST_HALF_KH));
  endtask

  task automatic test_kernel_load();
    for (int r = 0; r < NUM_LINES; r++)
      for (int c = 0; c < NUM_LINES; c++)
        send_coef(c, r, (r == 0 && c == 0) ? 16'sh8000 :
                        (r == 4 && c == 4) ? 16'sh7fff : coef_t'($urandom));
    // out-of-range kernel positions are dropped
    send_coef(5, 0, 16'sh7fff);
    send_coef(0, 6, 16'sh8000);
    send_coef(7, 7, 16'sh1234);
    drain();
  endtask

  task automatic test_wide_frame();
    // width above the line length clamps to a full line
    set_image(2047, 1, 2, 0);
    send_pixel(16'sh8000);
    send_pixel(16'sh7fff);
    finish_frame();
    drain();
  endtask

  task automatic test_tall_frame();
    // width 0 clamps to one column, half height 3 clamps to 2
    set_image(0, 40, 0, 3);
    finish_frame();
    drain();
  endtask

  task automatic test_too_small();
    set_image(2, 2, 2, 2);
    finish_frame();
    drain();
  endtask

  task automatic test_shrink_mid_frame();
    set_image(8, 6, 1, 1);
    repeat (20) send_pixel(rand_sample());
    drain();
    apb_write(REG_PIX_PER_ROW, 3);
    finish_frame();
    drain();
  endtask

  task automatic test_random_frames();
    int w, h;
    while (sent_items < ITEM_TARGET) begin
      if (sent_items > IDLE_STOP) begin
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
      end else begin
        src_idle_on = ($urandom_range(0, 4) != 0);
        snk_idle_on = ($urandom_range(0, 4) != 0);
      end
      w = $urandom_range(1, 20);
      h = $urandom_range(1, 8);
      case ($urandom_range(0, 11))
        0: w = 0;
        1: h = 1;
        2: h = 0;
        default: ;
      endcase
      set_image(w, h, $urandom_range(0, 3), $urandom_range(0, 3));
      do begin
        if ($urandom_range(0, 15) == 0)
          send_coef($urandom_range(0, 7), $urandom_range(0, 7), coef_t'($urandom));
        else
          send_pixel(rand_sample());
      end while (col_pos != 0 || row_pos != 0);
      drain();
    end
  endtask

  initial begin
    errors = 0;
    sent_items = 0;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    pix_if.valid = 1'b0; pix_if.action = ACT_SAMPLE; pix_if.sample = '0;
    pix_if.coef_col = '0; pix_if.coef_row = '0; pix_if.coef_value = '0;
    reg_width = RST_PIX_PER_ROW; reg_height = RST_ROWS_PER_FRAME;
    reg_hkw = RST_HALF_KW; reg_hkh = RST_HALF_KH;
    col_pos = 0; row_pos = 0;
    for (int r = 0; r < NUM_LINES; r++) begin
      for (int c = 0; c < NUM_LINES; c++) kern[r][c] = '0;
      for (int c = 0; c < LINE_LEN; c++) line_mem[r][c] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_kernel_load();
    test_wide_frame();
    test_tall_frame();
    test_too_small();
    test_shrink_mid_frame();
    test_random_frames();

    drain();
    if (pending_results.size() != 0) report("results still outstanding at end");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
